/* src/tl_pkg.sv */
`default_nettype none

package tl_pkg;

  // Token kinds as they leave the block.
  typedef enum logic [4:0] {
    TK_IF     = 5'd0,
    TK_THEN   = 5'd1,
    TK_PRINT  = 5'd2,
    TK_TRUE   = 5'd3,
    TK_FALSE  = 5'd4,
    TK_IDENT  = 5'd5,
    TK_ICONST = 5'd6,
    TK_SCONST = 5'd7,
    TK_PLUS   = 5'd8,
    TK_MINUS  = 5'd9,
    TK_STAR   = 5'd10,
    TK_SLASH  = 5'd11,
    TK_ASSIGN = 5'd12,
    TK_EQ     = 5'd13,
    TK_NEQ    = 5'd14,
    TK_LT     = 5'd15,
    TK_LEQ    = 5'd16,
    TK_GT     = 5'd17,
    TK_GEQ    = 5'd18,
    TK_AND    = 5'd19,
    TK_OR     = 5'd20,
    TK_SC     = 5'd21,
    TK_LPAREN = 5'd22,
    TK_RPAREN = 5'd23,
    TK_ERR    = 5'd24,
    TK_DONE   = 5'd25
  } kind_t;

  localparam int LINE_W  = 24;
  localparam int POS_W   = 32;
  localparam int LEN_W   = 16;
  localparam int INIT_W  = 16;
  localparam int TDATA_W = 72;

  // Token queue between the lexer and the output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    kind_t              kind;
    logic [LINE_W-1:0]  line;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic               last;
  } tok_t;

  // Up to two tokens written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } tl_push_t;

endpackage

`default_nettype wire

/* src/token_lexer.sv */
// Character lexer. One character enters per transfer on the in_ channel
// (in_tdata = character byte, in_tlast = end of input, character then
// ignored). Tokens leave on the out_ channel with the kind on out_tuser and
// line, lexeme start and length on out_tdata; out_tlast marks the final
// token caused by one input transfer.
// A character gives zero, one or two tokens; end of input gives the pending
// token (or an error token) and then DONE, after which a new stream starts
// at position 0 with the line count reloaded.
// The cfg_ channel writes the initial line number; it also reloads the line
// counter and must only be used while the block is idle.
// Throughput: one character per cycle while in_tready is high. The lexer state is
// registered; tokens pass through a four-entry queue drained one per cycle while
// out_tready is high, and input stalls once more than two tokens are queued, as
// when two-token characters outrun the output. A token goes from the queue into the
// output register to reach out_tvalid; the second token of a pair follows the first.
// Reset (rst_n low, synchronous) clears the lexer, the queue and the
// output register, and sets the initial line to 0. When the receiver holds
// out_tready low, the queue fills and in_tready drops; nothing is lost.
`default_nettype none

module token_lexer
  import tl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] ch
  input  wire logic               in_tlast,   // end_of_input
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [23:0] line_number, [55:24] lexeme_start,
                                              // [71:56] lexeme_length
  output logic [4:0]              out_tuser,  // [4:0] token_kind
  output logic                    out_tlast,  // last
  input  wire logic               cfg_tvalid,
  output logic                    cfg_tready,
  input  wire logic [INIT_W-1:0]  cfg_tdata   // [15:0] initial_line
);

  tl_push_t push;
  logic     q_room;
  logic     q_not_empty;
  logic     q_pop;
  tok_t     q_head;
  tok_t     out_tok;
  logic     in_fire;

  assign in_tready  = q_room;
  assign in_fire    = in_tvalid && q_room;
  assign cfg_tready = 1'b1;

  tl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ch    (in_tdata),
    .in_eoi   (in_tlast),
    .cfg_we   (cfg_tvalid),
    .cfg_data (cfg_tdata),
    .push     (push)
  );

  tl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (q_room),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_tok     (out_tok)
  );

  // Output packing, first field in the low bits.
  assign out_tdata = {out_tok.len, out_tok.start, out_tok.line};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule

`default_nettype wire

/* src/tl_front.sv */
`default_nettype none

module tl_front
  import tl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        in_ch,
  input  wire logic              in_eoi,
  input  wire logic              cfg_we,
  input  wire logic [INIT_W-1:0] cfg_data,
  output tl_push_t               push
);

  typedef enum logic [3:0] {
    M_BEGIN = 4'd0,
    M_ID    = 4'd1,
    M_STR   = 4'd2,
    M_EQ    = 4'd3,
    M_LT    = 4'd4,
    M_GT    = 4'd5,
    M_AND   = 4'd6,
    M_OR    = 4'd7,
    M_NOT   = 4'd8,
    M_INT   = 4'd9,
    M_CMT   = 4'd10
  } mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam int                NKW      = 5;

  // Keyword text, first character in the low byte: if, then, print, true, false.
  localparam logic [63:0] KW_TEXT [NKW] = '{
    64'h0000_0000_0000_6669,
    64'h0000_0000_6E65_6874,
    64'h0000_0074_6E69_7270,
    64'h0000_0000_6575_7274,
    64'h0000_0065_736C_6166
  };
  localparam logic [2:0] KW_LEN [NKW] = '{3'd2, 3'd4, 3'd5, 3'd4, 3'd5};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                              input logic [1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W-1){1'b0}}, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [LINE_W-1:0] l,
                                  input logic [POS_W-1:0] s, input logic [LEN_W-1:0] n);
    tok_t t;
    t.kind  = k;
    t.line  = l;
    t.start = s;
    t.len   = n;
    t.last  = 1'b0;
    return t;
  endfunction

  mode_t              mode_r, mode_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   ostart_r, ostart_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [NKW-1:0]     kwc_r, kwc_nxt;
  logic [INIT_W-1:0]  init_r;

  logic [LINE_W-1:0]  line_after;
  logic [LEN_W-1:0]   olen_inc;
  logic [NKW-1:0]     kwc_upd;
  kind_t              id_kind;

  // Token of the open lexeme when it is closed without taking the character.
  logic               pend_vld;
  tok_t               pend_tok;

  // Effect of a character that opens a new lexeme.
  mode_t              st_mode;
  logic               st_touch;
  logic [POS_W-1:0]   st_start;
  logic [LEN_W-1:0]   st_len;
  logic [NKW-1:0]     st_kwc;
  logic               st_emit;
  tok_t               st_tok;

  logic               a_vld, b_vld;
  tok_t               a_tok, b_tok;

  assign line_after = (in_ch == CH_NL && line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  assign olen_inc   = sat_add(olen_r, 2'd1);

  // Keyword candidates: drop those whose text does not continue with this character.
  always_comb begin
    for (int k = 0; k < NKW; k++) begin
      kwc_upd[k] = kwc_r[k] && (olen_r < {{(LEN_W-3){1'b0}}, KW_LEN[k]}) &&
                   (KW_TEXT[k][{olen_r[2:0], 3'b000} +: 8] == in_ch);
    end
  end

  // An identifier is a keyword when a candidate has exactly the lexeme length.
  always_comb begin
    logic found;
    found   = 1'b0;
    id_kind = TK_IDENT;
    for (int k = 0; k < NKW; k++) begin
      if (!found && kwc_r[k] && olen_r == {{(LEN_W-3){1'b0}}, KW_LEN[k]}) begin
        found   = 1'b1;
        id_kind = kind_t'(5'(k));
      end
    end
  end

  // Pending token, used at end of input and when a delimiter is put back.
  always_comb begin
    pend_vld = 1'b1;
    pend_tok = mk_tok(TK_ERR, line_r, ostart_r, 16'd1);
    unique case (mode_r)
      M_ID:  pend_tok = mk_tok(id_kind, line_r, ostart_r, olen_r);
      M_INT: pend_tok = mk_tok(TK_ICONST, line_r, ostart_r, olen_r);
      M_EQ:  pend_tok = mk_tok(TK_ASSIGN, line_r, ostart_r, 16'd1);
      M_LT:  pend_tok = mk_tok(TK_LT, line_r, ostart_r, 16'd1);
      M_GT:  pend_tok = mk_tok(TK_GT, line_r, ostart_r, 16'd1);
      M_AND, M_OR, M_NOT: pend_tok = mk_tok(TK_ERR, line_r, ostart_r, 16'd1);
      M_STR: pend_tok = mk_tok(TK_ERR, line_r, ostart_r - 1'b1, sat_add(olen_r, 2'd1));
      default: pend_vld = 1'b0;
    endcase
  end

  // Classification of a character that starts a lexeme.
  always_comb begin
    kind_t k;
    st_mode  = M_BEGIN;
    st_touch = !is_space(in_ch);
    st_start = pos_r;
    st_len   = 16'd1;
    st_kwc   = '0;
    st_emit  = 1'b0;
    k        = TK_ERR;
    if (is_alpha(in_ch)) begin
      st_mode = M_ID;
      for (int i = 0; i < NKW; i++) begin
        st_kwc[i] = (KW_TEXT[i][7:0] == in_ch);
      end
    end else if (is_digit(in_ch)) begin
      st_mode = M_INT;
    end else if (!is_space(in_ch)) begin
      unique case (in_ch)
        CH_QUOTE: begin
          st_mode  = M_STR;
          st_start = pos_r + 1'b1;
          st_len   = '0;
        end
        CH_EQ:     st_mode = M_EQ;
        CH_GT:     st_mode = M_GT;
        CH_LT:     st_mode = M_LT;
        CH_AMP:    st_mode = M_AND;
        CH_BAR:    st_mode = M_OR;
        CH_BANG:   st_mode = M_NOT;
        CH_HASH:   st_mode = M_CMT;
        CH_PLUS:   begin st_emit = 1'b1; k = TK_PLUS;   end
        CH_MINUS:  begin st_emit = 1'b1; k = TK_MINUS;  end
        CH_STAR:   begin st_emit = 1'b1; k = TK_STAR;   end
        CH_SLASH:  begin st_emit = 1'b1; k = TK_SLASH;  end
        CH_LPAREN: begin st_emit = 1'b1; k = TK_LPAREN; end
        CH_RPAREN: begin st_emit = 1'b1; k = TK_RPAREN; end
        CH_SEMI:   begin st_emit = 1'b1; k = TK_SC;     end
        default:   begin st_emit = 1'b1; k = TK_ERR;    end
      endcase
    end
    st_tok = mk_tok(k, line_after, pos_r, 16'd1);
  end

  // Lexer step: next state and up to two tokens (a before b).
  always_comb begin
    logic putback;
    putback    = 1'b0;
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    kwc_nxt    = kwc_r;
    a_vld      = 1'b0;
    a_tok      = pend_tok;
    b_vld      = 1'b0;
    b_tok      = st_tok;

    if (in_eoi) begin
      // Flush the open lexeme, close the stream and start a new one.
      a_vld      = pend_vld;
      b_vld      = 1'b1;
      b_tok      = mk_tok(TK_DONE, line_r, '0, '0);
      mode_nxt   = M_BEGIN;
      line_nxt   = {{(LINE_W-INIT_W){1'b0}}, init_r};
      pos_nxt    = '0;
      ostart_nxt = '0;
      olen_nxt   = '0;
      kwc_nxt    = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
      unique case (mode_r)
        M_ID: begin
          if (is_alpha(in_ch) || is_digit(in_ch)) begin
            kwc_nxt  = kwc_upd;
            olen_nxt = olen_inc;
          end else begin
            putback = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(in_ch)) begin
            olen_nxt = olen_inc;
          end else if (is_alpha(in_ch)) begin
            line_nxt = line_after;
            b_vld    = 1'b1;
            b_tok    = mk_tok(TK_ERR, line_after, ostart_r, olen_inc);
            mode_nxt = M_BEGIN;
          end else begin
            putback = 1'b1;
          end
        end
        M_STR: begin
          line_nxt = line_after;
          if (in_ch == CH_NL) begin
            b_vld    = 1'b1;
            b_tok    = mk_tok(TK_ERR, line_after, ostart_r - 1'b1, sat_add(olen_r, 2'd2));
            mode_nxt = M_BEGIN;
          end else if (in_ch == CH_QUOTE) begin
            b_vld    = 1'b1;
            b_tok    = mk_tok(TK_SCONST, line_after, ostart_r, olen_r);
            mode_nxt = M_BEGIN;
          end else begin
            olen_nxt = olen_inc;
          end
        end
        M_EQ, M_LT, M_GT: begin
          if (in_ch == CH_EQ) begin
            line_nxt = line_after;
            b_vld    = 1'b1;
            b_tok    = mk_tok(mode_r == M_EQ ? TK_EQ : (mode_r == M_LT ? TK_LEQ : TK_GEQ),
                              line_after, ostart_r, 16'd2);
            mode_nxt = M_BEGIN;
          end else begin
            putback = 1'b1;
          end
        end
        M_AND, M_OR, M_NOT: begin
          line_nxt = line_after;
          b_vld    = 1'b1;
          mode_nxt = M_BEGIN;
          if (mode_r == M_AND && in_ch == CH_AMP) begin
            b_tok = mk_tok(TK_AND, line_after, ostart_r, 16'd2);
          end else if (mode_r == M_OR && in_ch == CH_BAR) begin
            b_tok = mk_tok(TK_OR, line_after, ostart_r, 16'd2);
          end else if (mode_r == M_NOT && in_ch == CH_EQ) begin
            b_tok = mk_tok(TK_NEQ, line_after, ostart_r, 16'd2);
          end else begin
            b_tok = mk_tok(TK_ERR, line_after, ostart_r, 16'd1);
          end
        end
        M_CMT: begin
          line_nxt = line_after;
          if (in_ch == CH_NL) begin
            mode_nxt = M_BEGIN;
          end
        end
        default: begin
          line_nxt = line_after;
          mode_nxt = st_mode;
          if (st_touch) begin
            ostart_nxt = st_start;
            olen_nxt   = st_len;
            kwc_nxt    = st_kwc;
          end
          b_vld = st_emit;
        end
      endcase

      // A delimiter closes the open lexeme and is then lexed as a fresh character.
      if (putback) begin
        a_vld    = 1'b1;
        line_nxt = line_after;
        mode_nxt = st_mode;
        if (st_touch) begin
          ostart_nxt = st_start;
          olen_nxt   = st_len;
          kwc_nxt    = st_kwc;
        end
        b_vld = st_emit;
      end
    end
  end

  // Pack the tokens into the queue write, marking the final one.
  always_comb begin
    push.n  = 2'd0;
    push.t0 = a_tok;
    push.t1 = b_tok;
    if (a_vld && b_vld) begin
      push.n       = 2'd2;
      push.t1.last = 1'b1;
    end else if (a_vld) begin
      push.n       = 2'd1;
      push.t0.last = 1'b1;
    end else if (b_vld) begin
      push.n       = 2'd1;
      push.t0      = b_tok;
      push.t0.last = 1'b1;
    end
    if (!in_fire) begin
      push.n = 2'd0;
    end
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_BEGIN;
      line_r   <= '0;
      pos_r    <= '0;
      ostart_r <= '0;
      olen_r   <= '0;
      kwc_r    <= '0;
      init_r   <= '0;
    end else if (cfg_we) begin
      init_r <= cfg_data;
      line_r <= {{(LINE_W-INIT_W){1'b0}}, cfg_data};
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      ostart_r <= ostart_nxt;
      olen_r   <= olen_nxt;
      kwc_r    <= kwc_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tl_queue.sv */
`default_nettype none

module tl_queue
  import tl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  tl_push_t  push,
  output logic      has_room,
  input  wire logic pop,
  output logic      not_empty,
  output tok_t      head
);

  tok_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r;
  logic [Q_AW-1:0]  rp_r;
  logic [Q_CW-1:0]  cnt_r;
  logic [Q_AW-1:0]  wp1;
  logic             do_pop;

  assign wp1       = wp_r + 1'b1;
  assign has_room  = cnt_r <= Q_CW'(Q_DEPTH - 2);
  assign not_empty = cnt_r != '0;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rp_r];

  // Pointers and fill count; two writes and one read per cycle at most.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + Q_AW'(push.n);
      rp_r  <= rp_r + Q_AW'(do_pop);
      cnt_r <= cnt_r + Q_CW'(push.n) - Q_CW'(do_pop);
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.t0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp1] <= push.t1;
    end
  end

endmodule

`default_nettype wire

/* src/tl_back.sv */
`default_nettype none

module tl_back
  import tl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_not_empty,
  input  tok_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output tok_t      out_tok
);

  logic valid_r;
  tok_t tok_r;

  // Load the output register when it is empty or its token is being taken.
  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tok_r <= q_head;
    end
  end

endmodule

`default_nettype wire

/* dv/token_lexer_tb.sv */
module token_lexer_tb;
  import tl_pkg::*;

  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          DRAIN_HOLD  = 8;
  localparam logic [7:0]  CH_NL       = 8'h0A;
  localparam logic [7:0]  CH_QUOTE    = 8'h22;
  localparam logic [23:0] LINE_TOP    = 24'hFFFFFF;

  // Lexer modes of the predictor.
  typedef enum int {
    LM_BEGIN, LM_ID, LM_STR, LM_EQ, LM_LT, LM_GT, LM_AND, LM_OR, LM_NOT, LM_INT, LM_CMT
  } lex_mode_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [4:0]         out_tuser;
  logic               out_tlast;
  logic               cfg_tvalid = 1'b0;
  logic               cfg_tready;
  logic [INIT_W-1:0]  cfg_tdata  = '0;

  token_lexer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  // Predicted lexer state.
  lex_mode_t         mode       = LM_BEGIN;
  logic [INIT_W-1:0] first_line = '0;
  logic [LINE_W-1:0] line_cnt   = '0;
  logic [POS_W-1:0]  char_pos   = '0;
  logic [POS_W-1:0]  lex_start  = '0;
  logic [LEN_W-1:0]  lex_len    = '0;
  logic [4:0]        kw_mask    = '0;

  tok_t tokens_due[$];
  int   step_tokens;
  int   errors    = 0;
  int   n_sent    = 0;
  int   n_checked = 0;
  int   n_cfg     = 0;
  int   cycles    = 0;
  int   burst_left = 0;
  int   rx_stall  = 0;
  int   rx_run    = 0;
  bit   rx_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Keyword table.
  function automatic string kw_word(int k);
    case (k)
      0:       return "if";
      1:       return "then";
      2:       return "print";
      3:       return "true";
      default: return "false";
    endcase
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [LEN_W-1:0] len_plus(logic [LEN_W-1:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic kind_t word_kind();
    string w;
    for (int k = 0; k < 5; k++) begin
      w = kw_word(k);
      if (kw_mask[k] && w.len() == int'(lex_len)) return kind_t'(k);
    end
    return TK_IDENT;
  endfunction

  task automatic add_token(kind_t k, logic [LINE_W-1:0] ln, logic [POS_W-1:0] st,
                           logic [LEN_W-1:0] len);
    tok_t t;
    t.kind  = k;
    t.line  = ln;
    t.start = st;
    t.len   = len;
    t.last  = 1'b0;
    tokens_due.push_back(t);
    step_tokens++;
  endtask

  // Emit the token of a pending mode that ends without taking the character.
  task automatic flush_open(logic [LINE_W-1:0] ln);
    case (mode)
      LM_ID:  add_token(word_kind(), ln, lex_start, lex_len);
      LM_INT: add_token(TK_ICONST, ln, lex_start, lex_len);
      LM_EQ:  add_token(TK_ASSIGN, ln, lex_start, 16'd1);
      LM_LT:  add_token(TK_LT, ln, lex_start, 16'd1);
      LM_GT:  add_token(TK_GT, ln, lex_start, 16'd1);
      default: ;
    endcase
  endtask

  // Start a lexeme from the begin mode.
  task automatic open_lexeme(logic [7:0] c);
    string w;
    kind_t k;
    if (!is_blank(c)) begin
      lex_start = char_pos;
      lex_len   = 16'd1;
      kw_mask   = '0;
      k         = TK_ERR;
      mode      = LM_BEGIN;
      if (is_letter(c)) begin
        mode = LM_ID;
        for (int i = 0; i < 5; i++) begin
          w = kw_word(i);
          if (w[0] == c) kw_mask[i] = 1'b1;
        end
      end else if (is_digit(c)) begin
        mode = LM_INT;
      end else begin
        case (c)
          CH_QUOTE: begin
            mode      = LM_STR;
            lex_start = char_pos + 1;
            lex_len   = '0;
          end
          "=": mode = LM_EQ;
          ">": mode = LM_GT;
          "<": mode = LM_LT;
          "&": mode = LM_AND;
          "|": mode = LM_OR;
          "!": mode = LM_NOT;
          "#": mode = LM_CMT;
          "+": k = TK_PLUS;
          "-": k = TK_MINUS;
          "*": k = TK_STAR;
          "/": k = TK_SLASH;
          "(": k = TK_LPAREN;
          ")": k = TK_RPAREN;
          ";": k = TK_SC;
          default: ;
        endcase
        if (mode == LM_BEGIN) add_token(k, line_cnt, char_pos, 16'd1);
      end
    end
  endtask

  // Second character of a two-character operator, or an error if it is not.
  task automatic close_pair(logic [7:0] c, logic [7:0] second, kind_t pair, kind_t single,
                            logic [LINE_W-1:0] ln);
    line_cnt = ln;
    if (c == second) add_token(pair, line_cnt, lex_start, 16'd2);
    else add_token(single, line_cnt, lex_start, 16'd1);
    mode = LM_BEGIN;
  endtask

  // Work out the tokens caused by one accepted character or end mark.
  task automatic lex_char(logic [7:0] c, logic eoi);
    logic [LINE_W-1:0] l_after;
    bit                put_back;
    string             w;
    step_tokens = 0;
    put_back    = 1'b0;
    if (eoi) begin
      if (mode == LM_AND || mode == LM_OR || mode == LM_NOT)
        add_token(TK_ERR, line_cnt, lex_start, 16'd1);
      else if (mode == LM_STR)
        add_token(TK_ERR, line_cnt, lex_start - 1, len_plus(lex_len, 1));
      else
        flush_open(line_cnt);
      add_token(TK_DONE, line_cnt, '0, '0);
      mode      = LM_BEGIN;
      line_cnt  = LINE_W'(first_line);
      char_pos  = '0;
      lex_start = '0;
      lex_len   = '0;
      kw_mask   = '0;
    end else begin
      l_after = line_cnt;
      if (c == CH_NL && l_after < LINE_TOP) l_after++;
      case (mode)
        LM_ID: begin
          if (is_letter(c) || is_digit(c)) begin
            for (int k = 0; k < 5; k++) begin
              w = kw_word(k);
              if (int'(lex_len) >= w.len()) kw_mask[k] = 1'b0;
              else if (w[lex_len] != c) kw_mask[k] = 1'b0;
            end
            lex_len = len_plus(lex_len, 1);
          end else put_back = 1'b1;
        end
        LM_INT: begin
          if (is_digit(c)) begin
            lex_len = len_plus(lex_len, 1);
          end else if (is_letter(c)) begin
            line_cnt = l_after;
            add_token(TK_ERR, line_cnt, lex_start, len_plus(lex_len, 1));
            mode = LM_BEGIN;
          end else put_back = 1'b1;
        end
        LM_STR: begin
          line_cnt = l_after;
          if (c == CH_NL) begin
            add_token(TK_ERR, line_cnt, lex_start - 1, len_plus(lex_len, 2));
            mode = LM_BEGIN;
          end else if (c == CH_QUOTE) begin
            add_token(TK_SCONST, line_cnt, lex_start, lex_len);
            mode = LM_BEGIN;
          end else lex_len = len_plus(lex_len, 1);
        end
        LM_EQ:  if (c == "=") close_pair(c, "=", TK_EQ, TK_ASSIGN, l_after); else put_back = 1'b1;
        LM_LT:  if (c == "=") close_pair(c, "=", TK_LEQ, TK_LT, l_after); else put_back = 1'b1;
        LM_GT:  if (c == "=") close_pair(c, "=", TK_GEQ, TK_GT, l_after); else put_back = 1'b1;
        LM_AND: close_pair(c, "&", TK_AND, TK_ERR, l_after);
        LM_OR:  close_pair(c, "|", TK_OR, TK_ERR, l_after);
        LM_NOT: close_pair(c, "=", TK_NEQ, TK_ERR, l_after);
        LM_CMT: begin
          line_cnt = l_after;
          if (c == CH_NL) mode = LM_BEGIN;
        end
        default: begin
          mode     = LM_BEGIN;
          line_cnt = l_after;
          open_lexeme(c);
        end
      endcase
      // A delimiter that ends the open token is handled again from the begin mode.
      if (put_back) begin
        flush_open(line_cnt);
        mode     = LM_BEGIN;
        line_cnt = l_after;
        open_lexeme(c);
      end
      char_pos++;
    end
    if (step_tokens > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= 50)
      $display("token %0d: %s expected 0x%0h got 0x%0h", n_checked, what, want, got);
  endtask

  // Send one character in bursts with random gaps between them.
  task automatic send_char(logic [7:0] c, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_char(c, eoi);
    n_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic in_idle();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
  endtask

  // Wait until every expected token is out, then let the pipeline settle.
  task automatic wait_drain();
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  // Write the initial line number while the block is idle.
  task automatic write_line(logic [INIT_W-1:0] v);
    in_idle();
    wait_drain();
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= v;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    first_line = v;
    line_cnt   = LINE_W'(v);
    n_cfg++;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    while (b == CH_QUOTE || b == CH_NL) b = $urandom_range(0, 255);
    return b;
  endfunction

  function automatic logic [7:0] alnum_byte();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return 8'("0" + r - 52);
  endfunction

  function automatic string op_text(int i);
    case (i)
      0:  return "+";
      1:  return "-";
      2:  return "*";
      3:  return "/";
      4:  return "(";
      5:  return ")";
      6:  return ";";
      7:  return "=";
      8:  return "==";
      9:  return "<";
      10: return "<=";
      11: return ">";
      12: return ">=";
      13: return "!=";
      14: return "&&";
      15: return "||";
      16: return "&";
      17: return "|";
      default: return "!";
    endcase
  endfunction

  // One well-formed token with random content, or noise, a blank or an end mark.
  task automatic send_random_token();
    int    r, n;
    string w;
    logic [7:0] blanks[6];
    blanks = '{" ", 8'h09, CH_NL, 8'h0D, 8'h0B, 8'h0C};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // Keyword, a prefix of one, or one with an extra character.
      w = kw_word($urandom_range(0, 4));
      n = $urandom_range(0, 2);
      if (n == 1) send_text(w.substr(0, $urandom_range(0, w.len() - 2)));
      else send_text(w);
      if (n == 2) send_char(alnum_byte(), 1'b0);
    end else if (r < 25) begin
      send_char(($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                            : 8'("A" + $urandom_range(0, 25)), 1'b0);
      repeat ($urandom_range(0, 7)) send_char(alnum_byte(), 1'b0);
    end else if (r < 35) begin
      repeat ($urandom_range(1, 6)) send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 9) == 0) send_char(8'("a" + $urandom_range(0, 25)), 1'b0);
    end else if (r < 45) begin
      send_char(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 8)) send_char(text_byte(), 1'b0);
      send_char(($urandom_range(0, 6) == 0) ? CH_NL : CH_QUOTE, 1'b0);
    end else if (r < 75) begin
      send_text(op_text($urandom_range(0, 18)));
    end else if (r < 80) begin
      send_char("#", 1'b0);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(0, 255);
        send_char((n == CH_NL) ? 8'h41 : 8'(n), 1'b0);
      end
      send_char(CH_NL, 1'b0);
    end else if (r < 88) begin
      send_char(blanks[$urandom_range(0, 5)], 1'b0);
    end else if (r < 96) begin
      send_char(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_char(8'($urandom_range(0, 255)), 1'b1);
    end
    // Separator; none at all lets tokens run into each other.
    if ($urandom_range(0, 9) >= 4)
      repeat ($urandom_range(1, 2)) send_char(blanks[$urandom_range(0, 5)], 1'b0);
  endtask

  // Each special case at least once: keyword put back by an operator, a two-character
  // operator, an integer run into a letter, lone operators that swallow the next
  // character, a string broken by a newline, a comment, a byte outside ASCII, a NUL
  // byte and the end mark.
  task automatic test_directed_tokens();
    write_line(16'd37);
    send_text("print>=7a!x&&|y\"a\n#c\n");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_stream(logic [INIT_W-1:0] start_line, int count);
    int goal;
    write_line(start_line);
    goal = n_sent + count;
    while (n_sent < goal) send_random_token();
  endtask

  // Receiver: stalls of random length between runs that are steady or ragged.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else if (rx_run > 0) begin
      out_tready <= rx_steady || ($urandom_range(0, 1) != 0);
      rx_run--;
    end else begin
      out_tready <= 1'b0;
      if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 20);
      rx_run    = $urandom_range(1, 60);
      rx_steady = ($urandom_range(0, 1) != 0);
    end
  end

  // Compare every token transfer with the oldest expected token.
  always @(posedge clk) begin : check_tokens
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("token with none expected, kind", 0, out_tuser);
      end else begin
        want = tokens_due.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("kind", want.kind, out_tuser);
        if (out_tdata[23:0] !== want.line)
          report_mismatch("line", want.line, out_tdata[23:0]);
        if (out_tdata[55:24] !== want.start)
          report_mismatch("lexeme start", want.start, out_tdata[55:24]);
        if (out_tdata[71:56] !== want.len)
          report_mismatch("lexeme length", want.len, out_tdata[71:56]);
        if (out_tlast !== want.last)
          report_mismatch("last", want.last, out_tlast);
      end
      n_checked++;
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d tokens outstanding", cycles,
               tokens_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_tokens();
    test_random_stream(16'hFFFF, 300);
    test_random_stream(16'h0000, 300);
    test_random_stream(16'($urandom_range(1, 65534)), 300);
    test_random_stream(16'h0001, 300);
    in_idle();
    wait_drain();
    $display("Lexed %0d characters and end marks into %0d checked tokens", n_sent, n_checked);
    $display("across %0d initial line settings, with stalls on both sides.", n_cfg);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
